@@ src/swq_pkg.sv @@
// ----------------------------------------------------------------------------
// swq_pkg: shared types and constants
// Request and status codes, field widths and the ring control bundle.
// ----------------------------------------------------------------------------
package swq_pkg;

	localparam int unsigned TID_W    = 8;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned STATUS_W = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WAIT   = 2'd0,
		ACT_TRY    = 2'd1,
		ACT_SIGNAL = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED     = 3'd0,
		ST_QUEUED      = 3'd1,
		ST_WOULD_BLOCK = 3'd2,
		ST_FULL        = 3'd3,
		ST_RAISED      = 3'd4,
		ST_WOKEN       = 3'd5
	} status_t;

	// control from the request logic to the waiter ring
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ring_ctl_t;

endpackage

@@ src/semaphore_with_wait_queue.sv @@
// ----------------------------------------------------------------------------
// semaphore_with_wait_queue: counting semaphore with a FIFO of waiters
// Request channel (req_*) carries action and thread_id; response channel
// (rsp_*) returns status, woken_thread and count_now, one word per request.
// A word is taken at a clock edge where valid is high and stall is low.
//
// A request accepted into the input register has its response registered in
// the response register once that register can advance, which raises rsp_valid.
// One request per cycle is sustained while the receiver does not stall: the
// count update, the ring compare and the ring read or write all resolve in
// the single stage between the input register and the response register.
// When the receiver stalls, the response register holds its word; an empty
// input register still takes one request, and once it holds one req_stall
// stays high until the response is taken.
// Reset clears the count, both configuration registers and the ring pointers.
// Writing either APB register reloads the count (any nonzero value loads as 1
// in binary mode) and empties the ring; writes are expected only while idle.
// ----------------------------------------------------------------------------
module semaphore_with_wait_queue import swq_pkg::*; #(
	parameter int unsigned QUEUE_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [TID_W-1:0]    thread_id,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TID_W-1:0]    woken_thread,
	output logic [COUNT_W-1:0]  count_now,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                binary_mode_q;
	logic [COUNT_W-1:0]  initial_count_q;
	logic [COUNT_W-1:0]  count_q;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [TID_W-1:0]    tid_s1;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TID_W-1:0]    woken_q;
	logic [COUNT_W-1:0]  count_now_q;

	logic                cfg_wr;
	logic                new_mode;
	logic [COUNT_W-1:0]  new_init;
	logic                advance;
	logic                fire;

	ring_ctl_t           ring_ctl;
	logic                ring_empty, ring_full;
	logic [TID_W-1:0]    ring_head_word;

	logic [COUNT_W-1:0]  count_nxt;
	status_t             status_nxt;
	logic [TID_W-1:0]    woken_nxt;
	logic [COUNT_W-1:0]  taken_count;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign new_mode = (cfg_wr && !paddr[2]) ? pwdata[0] : binary_mode_q;
	assign new_init = (cfg_wr && paddr[2]) ? pwdata[COUNT_W-1:0] : initial_count_q;

	always_comb begin
		if (paddr[2])
			prdata = {{(32-COUNT_W){1'b0}}, initial_count_q};
		else
			prdata = {31'd0, binary_mode_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary_mode_q   <= 1'b0;
			initial_count_q <= '0;
		end else if (cfg_wr) begin
			binary_mode_q   <= new_mode;
			initial_count_q <= new_init;
		end
	end

	// ---------------- input register ----------------
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign fire      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!req_stall)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			action_s1 <= action;
			tid_s1    <= thread_id;
		end
	end

	// ---------------- request logic ----------------
	assign taken_count = binary_mode_q ? '0 : count_q - 1'b1;

	always_comb begin
		count_nxt     = count_q;
		status_nxt    = ST_WOULD_BLOCK;
		woken_nxt     = '0;
		ring_ctl.push = 1'b0;
		ring_ctl.pop  = 1'b0;
		ring_ctl.clear = cfg_wr;
		case (action_s1)
			ACT_WAIT: begin
				if (count_q != '0) begin
					count_nxt  = taken_count;
					status_nxt = ST_GRANTED;
				end else if (ring_full) begin
					status_nxt = ST_FULL;
				end else begin
					ring_ctl.push = fire;
					status_nxt    = ST_QUEUED;
				end
			end
			ACT_TRY: begin
				if (count_q != '0) begin
					count_nxt  = taken_count;
					status_nxt = ST_GRANTED;
				end
			end
			ACT_SIGNAL: begin
				if (!ring_empty) begin
					ring_ctl.pop = fire;
					woken_nxt    = ring_head_word;
					status_nxt   = ST_WOKEN;
				end else begin
					if (binary_mode_q)
						count_nxt = COUNT_W'(1);
					else if (count_q != COUNT_MAX)
						count_nxt = count_q + 1'b1;
					status_nxt = ST_RAISED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cfg_wr)
			count_q <= new_mode ? COUNT_W'(new_init != '0) : new_init;
		else if (fire)
			count_q <= count_nxt;
	end

	swq_ring #(
		.SLOTS(QUEUE_SLOTS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.wdata     (tid_s1),
		.empty     (ring_empty),
		.full      (ring_full),
		.head_word (ring_head_word)
	);

	// ---------------- response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (advance)
			rsp_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_nxt;
			woken_q     <= woken_nxt;
			count_now_q <= count_nxt;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign woken_thread = woken_q;
	assign count_now    = count_now_q;

endmodule

@@ src/swq_ring.sv @@
// ----------------------------------------------------------------------------
// swq_ring: ring of waiting thread ids
// Head and tail pointers over a small memory. The head entry is kept in a
// registered read port, prefetched at the next head address every cycle.
// ----------------------------------------------------------------------------
module swq_ring import swq_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ring_ctl_t        ctl,
	input  logic [TID_W-1:0] wdata,
	output logic             empty,
	output logic             full,
	output logic [TID_W-1:0] head_word
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

	logic [TID_W-1:0] mem [SLOTS];
	logic [IDX_W-1:0] head_q, tail_q;
	logic [IDX_W-1:0] head_inc, tail_inc;
	logic [IDX_W-1:0] head_nxt, tail_nxt;
	logic [TID_W-1:0] rd_q;

	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + 1'b1;

	assign empty     = (head_q == tail_q);
	assign full      = (head_q == tail_inc);
	assign head_word = rd_q;

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		if (ctl.clear) begin
			head_nxt = '0;
			tail_nxt = '0;
		end else begin
			if (ctl.pop)
				head_nxt = head_inc;
			if (ctl.push)
				tail_nxt = tail_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
		end
	end

	// write-first bypass: a push into an empty ring lands at the next head
	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear)
			mem[tail_q] <= wdata;
		if (ctl.push && !ctl.clear && (tail_q == head_nxt))
			rd_q <= wdata;
		else
			rd_q <= mem[head_nxt];
	end

endmodule

@@ src/swq_checker.sv @@
// ----------------------------------------------------------------------------
// swq_checker: port-level checks for the semaphore block
// Watches the response channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swq_checker import swq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [STATUS_W-1:0] status,
	input logic [TID_W-1:0]    woken_thread,
	input logic [COUNT_W-1:0]  count_now
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
			&& $stable(woken_thread) && $stable(count_now))
		else $error("response word changed while stalled");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_WOKEN) |-> woken_thread == '0)
		else $error("woken_thread nonzero without a wake");

	// a waiter only queues or overflows when no unit is left
	a_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_QUEUED || status == ST_FULL) |-> count_now == '0)
		else $error("wait blocked with a nonzero count");

	a_raise_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_RAISED) |-> count_now != '0)
		else $error("signal left the count at zero");

endmodule

bind semaphore_with_wait_queue swq_checker u_swq_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for semaphore_with_wait_queue
// Drives requests and APB register writes, predicts each response word from
// a software copy of the count and the waiter FIFO, and compares every field.
// ----------------------------------------------------------------------------
module tb;
	import swq_pkg::*;

	localparam int ITEMS  = 1950;
	localparam int PHASES = 8;
	localparam int LIMIT  = 400000;
	localparam int SLOTS  = 16;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_INIT = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [TID_W-1:0]    woken;
		logic [COUNT_W-1:0]  cnt;
	} sem_reply_t;

	class sem_scoreboard;
		bit                 mode;
		logic [COUNT_W-1:0] init_val;
		logic [COUNT_W-1:0] count;
		logic [TID_W-1:0]   waiters[$];
		sem_reply_t         replies[$];
		int                 errors;

		function new();
			mode = 0;
			init_val = '0;
			errors = 0;
			reload();
		endfunction

		function void reload();
			count = mode ? COUNT_W'(init_val != 0) : init_val;
			waiters.delete();
		endfunction

		function void configure(logic [2:0] addr, logic [31:0] val);
			if (addr == REG_MODE)
				mode = val[0];
			else
				init_val = val[COUNT_W-1:0];
			reload();
		endfunction

		function bit take_unit();
			if (count == 0)
				return 0;
			count = mode ? '0 : count - 1'b1;
			return 1;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", what);
		endfunction

		function void note(logic [ACTION_W-1:0] act, logic [TID_W-1:0] tid);
			sem_reply_t r;
			r.st = ST_WOULD_BLOCK;
			r.woken = '0;
			case (act)
				ACT_WAIT: begin
					if (take_unit())
						r.st = ST_GRANTED;
					else if (waiters.size() == SLOTS - 1)
						r.st = ST_FULL;
					else begin
						waiters.push_back(tid);
						r.st = ST_QUEUED;
					end
				end
				ACT_TRY: r.st = take_unit() ? ST_GRANTED : ST_WOULD_BLOCK;
				ACT_SIGNAL: begin
					if (waiters.size() != 0) begin
						r.woken = waiters.pop_front();
						r.st = ST_WOKEN;
					end else begin
						if (mode)
							count = 1;
						else if (count != COUNT_MAX)
							count = count + 1'b1;
						r.st = ST_RAISED;
					end
				end
				default: ;
			endcase
			r.cnt = count;
			replies.push_back(r);
		endfunction

		function void check(logic [STATUS_W-1:0] st, logic [TID_W-1:0] woken,
				logic [COUNT_W-1:0] cnt);
			sem_reply_t e;
			if (replies.size() == 0) begin
				flag($sformatf("response word with none pending: st=%0d woken=%0d cnt=%0d",
					st, woken, cnt));
				return;
			end
			e = replies.pop_front();
			if (st !== e.st || woken !== e.woken || cnt !== e.cnt)
				flag($sformatf("exp st=%0d woken=%0d cnt=%0d, got st=%0d woken=%0d cnt=%0d",
					e.st, e.woken, e.cnt, st, woken, cnt));
		endfunction

		function int pending();
			return replies.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [ACTION_W-1:0] action;
	logic [TID_W-1:0]    thread_id;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [TID_W-1:0]    woken_thread;
	logic [COUNT_W-1:0]  count_now;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	sem_scoreboard sb = new();
	int cycles = 0;
	int gap_pct = 30;
	int stall_pct = 30;
	int stall_left = 0;
	bit quiet = 0;

	semaphore_with_wait_queue dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.action(action), .thread_id(thread_id),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .woken_thread(woken_thread), .count_now(count_now),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note(action, thread_id);
			if (rsp_valid && !rsp_stall)
				sb.check(status, woken_thread, count_now);
		end
	end

	// random receiver stall bursts
	initial begin
		rsp_stall = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_stall <= 1;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				rsp_stall <= 1;
				stall_left = $urandom_range(0, 8);
			end else
				rsp_stall <= 0;
		end
	end

	task automatic send_req(input logic [ACTION_W-1:0] act, input logic [TID_W-1:0] tid);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			req_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1;
		action <= act;
		thread_id <= tid;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// let every pending word come back before touching the registers
	task automatic drain();
		@(negedge clk);
		req_valid <= 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
		logic [31:0] mask;
		mask = (addr == REG_MODE) ? 32'h1 : 32'hFFFF;
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.configure(addr, val);
		// read back through the same port
		@(negedge clk);
		pwrite <= 0;
		penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask))
			sb.flag($sformatf("readback addr %0d exp %0h got %0h", addr, val & mask, prdata));
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 32'hFFFF;
			3: return 32'hFFFE;
			4: return $urandom_range(2, 20);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin
		int per_phase;
		int sent;
		int wait_w;
		int try_w;
		int r;
		logic [ACTION_W-1:0] act;

		arst_n = 0;
		req_valid = 0;
		action = ACT_WAIT;
		thread_id = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// state straight out of reset
		send_req(ACT_TRY, 8'h00);
		send_req(ACT_SIGNAL, 8'hFF);
		drain();

		// empty count: fill the FIFO, overflow it, then wake the two oldest
		cfg_write(REG_MODE, 32'h0);
		cfg_write(REG_INIT, 32'h0);
		send_req(ACT_WAIT, 8'hFF);
		for (int i = 1; i < SLOTS - 1; i++)
			send_req(ACT_WAIT, TID_W'(i));
		send_req(ACT_WAIT, 8'h55);
		send_req(ACT_UNUSED, 8'hAA);
		send_req(ACT_SIGNAL, 8'h00);
		send_req(ACT_SIGNAL, 8'h00);
		drain();

		// saturated count, then boolean mode reload
		cfg_write(REG_INIT, 32'hFFFF_FFFF);
		send_req(ACT_SIGNAL, 8'h01);
		send_req(ACT_WAIT, 8'h02);
		drain();
		cfg_write(REG_MODE, 32'h1);
		send_req(ACT_WAIT, 8'h03);
		send_req(ACT_TRY, 8'h04);
		send_req(ACT_SIGNAL, 8'h05);
		send_req(ACT_SIGNAL, 8'h06);
		drain();

		per_phase = ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == PHASES - 1);
			gap_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 50);
			stall_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 50);
			cfg_write(REG_MODE, $urandom_range(0, 1));
			cfg_write(REG_INIT, pick_count());
			case ($urandom_range(0, 3))
				0: wait_w = 20;
				1: wait_w = 35;
				2: wait_w = 50;
				default: wait_w = 65;
			endcase
			try_w = $urandom_range(10, 20);
			sent = 0;
			while (sent < per_phase) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					act = ACT_UNUSED;
				else if (r < 3 + wait_w)
					act = ACT_WAIT;
				else if (r < 3 + wait_w + try_w)
					act = ACT_TRY;
				else
					act = ACT_SIGNAL;
				send_req(act, TID_W'($urandom_range(0, 255)));
				if (act != ACT_UNUSED)
					sent++;
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
